// File: hw/rtl/isa_pkg.sv
// Package with shared types and constants for the scatter-add block.
package isa_pkg;
   localparam int MaxRows   = 256;
   localparam int MaxCols   = 16;
   localparam int RowBits   = $clog2(MaxRows);
   localparam int ColBits   = $clog2(MaxCols);
   localparam int AddrBits  = RowBits + ColBits;
   localparam int Depth     = MaxRows * MaxCols;
   localparam logic [31:0] CanonNan = 32'h7FC00000;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ACCUM = 2'd1,
      CMD_READ  = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_ROWS  = 1'b0,
      CSR_WIDTH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              write;
      logic [AddrBits-1:0] addr;
      logic [31:0]       data;
   } mem_write_type;
endpackage

// File: hw/rtl/isa_store.sv
// Simple dual-port synchronous store of fp32 words with registered read data.
module isa_store
   import isa_pkg::*;
(
   input  logic                clock,
   input  logic [AddrBits-1:0] rd_addr,
   input  mem_write_type       wr,
   output logic [31:0]         rd_data
);
   logic [31:0] mem_ff [Depth];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.write) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/isa_fadd.sv
// Two-stage fp32 adder, round to nearest even, subnormals kept, NaN canonical.
module isa_fadd
   import isa_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] sum
);
   // Stage 1: unpack, swap, align into a wide fixed frame.
   logic        sa, sb, big_s, sml_s, special, sub;
   logic [7:0]  ea, eb, big_e, sml_e, dexp;
   logic [23:0] ma, mb, big_m, sml_m;
   logic [26:0] sml_al;
   logic [31:0] spec_val;
   logic        a_nan, b_nan, a_inf, b_inf;

   logic        s1_sign_ff, s1_special_ff, s1_sub_ff, s1_sml_s_ff;
   logic [7:0]  s1_exp_ff;
   logic [26:0] s1_big_ff, s1_sml_ff;
   logic [31:0] s1_spec_ff;

   always_comb begin
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      ma = {(ea != 8'd0), a[22:0]};
      mb = {(eb != 8'd0), b[22:0]};
      if (ea == 8'd0) ea = 8'd1;
      if (eb == 8'd0) eb = 8'd1;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      special = a_nan || b_nan || a_inf || b_inf;
      if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) spec_val = CanonNan;
      else if (a_inf) spec_val = a;
      else spec_val = b;
      if ({ea, ma} >= {eb, mb}) begin
         big_s = sa; big_e = ea; big_m = ma; sml_s = sb; sml_e = eb; sml_m = mb;
      end else begin
         big_s = sb; big_e = eb; big_m = mb; sml_s = sa; sml_e = ea; sml_m = ma;
      end
      dexp = big_e - sml_e;
      sub = big_s != sml_s;
      if (dexp > 8'd26) begin
         sml_al = {26'd0, (sml_m != 24'd0)};
      end else begin
         sml_al = ({sml_m, 3'b000} >> dexp[4:0]);
         if ((({sml_m, 3'b000}) & ~(27'h7FFFFFF << dexp[4:0])) != 27'd0) begin
            sml_al[0] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_sign_ff    <= big_s;
      s1_sml_s_ff   <= sml_s;
      s1_special_ff <= special;
      s1_sub_ff     <= sub;
      s1_exp_ff     <= big_e;
      s1_big_ff     <= {big_m, 3'b000};
      s1_sml_ff     <= sml_al;
      s1_spec_ff    <= spec_val;
   end

   // Stage 2: add, normalize, round.
   logic [27:0] raw;
   logic [27:0] nrm;
   logic [9:0]  e;
   logic [4:0]  lz;
   logic [23:0] mant;
   logic [24:0] rnd;
   logic        guard, sticky, lsb, found;
   logic [31:0] res;
   logic [9:0]  shl;

   always_comb begin
      if (s1_sub_ff) raw = {1'b0, s1_big_ff} - {1'b0, s1_sml_ff};
      else           raw = {1'b0, s1_big_ff} + {1'b0, s1_sml_ff};
      lz = 5'd0;
      found = 1'b0;
      for (int i = 27; i >= 0; i--) begin
         if (!found && raw[i]) begin
            found = 1'b1;
            lz = 5'(27 - i);
         end
      end
      e = {2'b00, s1_exp_ff} + 10'd1;
      shl = 10'd0;
      nrm = raw;
      if (raw[27]) begin
         nrm = raw;
      end else begin
         shl = {5'd0, lz};
         if ({2'b00, s1_exp_ff} <= shl) shl = {2'b00, s1_exp_ff};
         nrm = raw << shl[4:0];
         e = {2'b00, s1_exp_ff} + 10'd1 - shl;
      end
      // nrm[27:4] mantissa, nrm[3] guard, nrm[2:0] sticky
      mant = nrm[27:4];
      guard = nrm[3];
      sticky = nrm[2:0] != 3'd0;
      lsb = mant[0];
      rnd = {1'b0, mant} + {24'd0, (guard && (sticky || lsb))};
      if (rnd[24]) begin
         rnd = {1'b0, rnd[24:1]};
         e = e + 10'd1;
      end
      if (raw == 28'd0) begin
         res = {(s1_sign_ff && s1_sml_s_ff), 31'd0};
      end else if (!rnd[23]) begin
         res = {s1_sign_ff, 8'd0, rnd[22:0]};
      end else if (e >= 10'd255) begin
         res = {s1_sign_ff, 8'hFF, 23'd0};
      end else begin
         res = {s1_sign_ff, e[7:0], rnd[22:0]};
      end
      sum = s1_special_ff ? s1_spec_ff : res;
   end
endmodule

// File: hw/rtl/index_scatter_add.sv
// Top level of the scatter-add accumulator: control, store and adder.
//
// Channel  Direction  Handshake      Contents
// req_     in         valid / stall  command, row_index, column, value
// rsp_     out        valid / stall  read_value, index_error
// csr_     in         valid / ready  index, data
//
// From one input transfer to the next, an accumulate passes through store read, two adder
// stages and writeback; a read through store read and the first adder state; a load
// through store read only. Out-of-range items are answered from idle. One item is in
// flight at a time; the next item is taken once the result register is free. Reset
// clears control and loads rows_in_use = 256 and row_width = 16; the store is not cleared.
module index_scatter_add
   import isa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_row_index,
   input  logic [3:0]  req_column,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_value,
   output logic        rsp_index_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_READ = 4'b0010,
      ST_ADD1 = 4'b0100,
      ST_ADD2 = 4'b1000
   } state_type;

   state_type     state_ff, state_in;
   logic [8:0]    rows_ff;
   logic [4:0]    width_ff;
   cmd_type       cmd_ff;
   logic [AddrBits-1:0] addr_ff;
   logic [31:0]   val_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_err_ff, rsp_err_in;
   logic [31:0]   rd_data, sum;
   mem_write_type wr;
   logic          accept, in_range;

   isa_store u_store (.clock(clock), .rd_addr(addr_ff), .wr(wr), .rd_data(rd_data));
   isa_fadd  u_fadd  (.clock(clock), .a(rd_data), .b(val_ff), .sum(sum));

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign in_range  = ({1'b0, req_row_index} < rows_ff) && ({1'b0, req_column} < width_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;
      wr.write     = 1'b0;
      wr.addr      = addr_ff;
      wr.data      = sum;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!in_range) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = 32'd0;
                  rsp_err_in   = 1'b1;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            case (cmd_ff)
               CMD_LOAD: begin
                  wr.write     = 1'b1;
                  wr.data      = val_ff;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = val_ff;
                  rsp_err_in   = 1'b0;
                  state_in     = ST_IDLE;
               end
               CMD_ACCUM: state_in = ST_ADD1;
               default: begin
                  state_in = ST_ADD1;
               end
            endcase
         end
         ST_ADD1: begin
            if (cmd_ff == CMD_ACCUM) begin
               state_in = ST_ADD2;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_data;
               rsp_err_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_ADD2: begin
            wr.write     = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = sum;
            rsp_err_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= 9'd256;
         width_ff     <= 5'd16;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS:  rows_ff  <= csr_data[8:0];
               CSR_WIDTH: width_ff <= csr_data[4:0];
               default: ;
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
      if (accept) begin
         cmd_ff  <= cmd_type'(req_command);
         addr_ff <= {req_row_index, req_column};
         val_ff  <= req_value;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_data_ff;
   assign rsp_index_error = rsp_err_ff;
endmodule
